// ----- hw/rtl/tcp_header_parser_payload_capture_unit_defines.svh -----
// Assertion macros for the TCP header parser and payload capture unit.
`ifndef TCP_HEADER_PARSER_PAYLOAD_CAPTURE_UNIT_DEFINES_SVH
`define TCP_HEADER_PARSER_PAYLOAD_CAPTURE_UNIT_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define THPC_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define THPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/thpc_pkg.sv -----
// Shared constants and types for the TCP header parser and payload capture unit.
package thpc_pkg;

    // Byte positions inside an Ethernet / IPv4 (no options) / TCP frame.
    localparam int ETH_TYPE_HI_POS = 12;
    localparam int ETH_TYPE_LO_POS = 13;
    localparam int IP_PROTO_POS    = 23;
    localparam int SRC_ADDR_POS    = 26;
    localparam int DST_ADDR_POS    = 30;
    localparam int TCP_START_POS   = 34;
    localparam int SEQ_POS         = 38;
    localparam int ACK_POS         = 42;
    localparam int DATA_OFFSET_POS = 46;
    localparam int TCP_FLAGS_POS   = 47;
    localparam int MIN_PAYLOAD_POS = 54;
    localparam int WORD_BYTES      = 4;

    localparam logic [7:0] ETH_TYPE_IPV4_HI = 8'h08;
    localparam logic [7:0] ETH_TYPE_IPV4_LO = 8'h00;
    localparam logic [7:0] IP_PROTO_TCP     = 8'h06;
    localparam logic [3:0] MIN_HDR_WORDS    = 4'd5;

    localparam int FLAG_W   = 6;
    localparam int CAPLEN_W = 9;

    // Output fields other than frame_length, in bits.
    localparam int FIXED_FIELD_BITS = 183;

    localparam logic REC_KIND_PAYLOAD = 1'b0;
    localparam logic REC_KIND_SUMMARY = 1'b1;

    // Output queue sizing.
    localparam int OUTQ_DEPTH = 8;
    localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

    // Records written into the output queue by one parsed byte.
    typedef struct packed {
        logic first;
        logic second;
    } push_t;

endpackage

// ----- hw/rtl/tcp_header_parser_payload_capture_unit.sv -----
// Top level of the Ethernet / IPv4 / TCP header parser with payload capture.
//
//  Channel   Direction  Carries
//  s_axis    in         one frame byte per transaction, tlast on the final byte
//  m_axis    out        payload byte record (tuser 0) or frame summary (tuser 1, tlast 1)
//
// One frame byte is taken every cycle while s_tready is high; its records pass the input
// stage, then the output queue. A final byte that is itself captured gives two records,
// so the queue of eight entries absorbs bursts; s_tready drops only when the queue plus
// the byte in parsing could overfill it. Reset clears parse state, queue and input stage.
`include "tcp_header_parser_payload_capture_unit_defines.svh"

module tcp_header_parser_payload_capture_unit #(
    parameter int MAX_CAPTURE = 256,
    parameter int LENGTH_BITS = 14,
    localparam int DATA_W = ((thpc_pkg::FIXED_FIELD_BITS + LENGTH_BITS + 7) / 8) * 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // [7:0] frame_byte
    input  logic              s_tlast,
    output logic              m_tvalid,
    input  logic              m_tready,
    // from bit 0: source_address 32, dest_address 32, source_port 16, dest_port 16,
    // sequence_number 32, acknowledge_number 32, flag_bits 6, frame_length LENGTH_BITS,
    // captured_length 9, payload_byte 8, zero fill
    output logic [DATA_W-1:0] m_tdata,
    output logic              m_tuser,   // [0] record_kind
    output logic              m_tlast
);

    localparam int CNW = thpc_pkg::OUTQ_CNT_W;

    logic                pending;
    thpc_pkg::push_t     push;
    logic [DATA_W+1:0]   rec0;
    logic [DATA_W+1:0]   rec1;
    logic [DATA_W+1:0]   out_entry;
    logic [CNW-1:0]      fifo_count;
    logic [CNW:0]        committed;
    logic                s_accept;

    thpc_parser #(
        .MAX_CAPTURE(MAX_CAPTURE),
        .LENGTH_BITS(LENGTH_BITS),
        .DATA_W(DATA_W)
    ) u_parser (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(s_accept),
        .in_byte(s_tdata),
        .in_last(s_tlast),
        .pending(pending),
        .push(push),
        .rec0(rec0),
        .rec1(rec1)
    );

    thpc_out_fifo #(
        .W(DATA_W + 2)
    ) u_out_fifo (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .rec0(rec0),
        .rec1(rec1),
        .pop(m_tready),
        .out_valid(m_tvalid),
        .out_entry(out_entry),
        .count(fifo_count)
    );

    // Each byte in flight may still add two records to the queue.
    assign committed = {1'b0, fifo_count} + (pending ? (CNW+1)'(2) : '0);
    assign s_tready  = (committed <= (CNW+1)'(thpc_pkg::OUTQ_DEPTH - 2));
    assign s_accept  = s_tvalid && s_tready;

    assign m_tlast = out_entry[DATA_W+1];
    assign m_tuser = out_entry[DATA_W];
    assign m_tdata = out_entry[DATA_W-1:0];

    `THPC_ASSERT_IMPLY(a_queue_bound, clk, rst_n, 1'b1, committed <= (CNW+1)'(thpc_pkg::OUTQ_DEPTH), "queue over")
    `THPC_ASSERT_NEXT(a_accept_parsed, clk, rst_n, s_accept, pending, "accepted byte was not registered")
    `THPC_ASSERT_IMPLY(a_summary_last, clk, rst_n, m_tvalid, m_tlast == m_tuser, "tlast not on summary")
    `THPC_ASSERT_IMPLY(a_summary_len, clk, rst_n, m_tvalid && m_tuser, m_tdata[166+LENGTH_BITS +: 9] != '0, "empty summary")

endmodule

// ----- hw/rtl/thpc_parser.sv -----
// Input register, header field extraction and record generation.
module thpc_parser #(
    parameter int MAX_CAPTURE = 256,
    parameter int LENGTH_BITS = 14,
    parameter int DATA_W      = 200
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic [7:0]            in_byte,
    input  logic                  in_last,
    output logic                  pending,
    output thpc_pkg::push_t       push,
    output logic [DATA_W+1:0]     rec0,
    output logic [DATA_W+1:0]     rec1
);

    localparam int LB = LENGTH_BITS;
    localparam int CW = $clog2(MAX_CAPTURE + 1);
    localparam int PAYLOAD_LSB = thpc_pkg::FIXED_FIELD_BITS - 8 + LB;

    logic             in_vld_reg, in_vld_next;
    logic [7:0]       byte_reg;
    logic             last_reg;

    logic [LB-1:0]    pos_reg, pos_next;
    logic             ok_reg, ok_next;
    logic [7:0]       type_hi_reg, type_hi_next;
    logic [31:0]      src_reg, src_next;
    logic [31:0]      dst_reg, dst_next;
    logic [31:0]      ports_reg, ports_next;
    logic [31:0]      seq_reg, seq_next;
    logic [31:0]      ack_reg, ack_next;
    logic [thpc_pkg::FLAG_W-1:0] flags_reg, flags_next;
    logic [3:0]       hw_reg, hw_next;
    logic [CW-1:0]    cnt_reg, cnt_next;

    logic [LB-1:0]    pos_inc;
    logic [LB-1:0]    payload_start;
    logic             capture;
    logic             summary;
    logic [CW-1:0]    cnt_after;
    logic [CW+thpc_pkg::CAPLEN_W-1:0] cnt_wide;
    logic [DATA_W-1:0] payload_data;
    logic [DATA_W-1:0] summary_data;
    logic [DATA_W+1:0] payload_rec;
    logic [DATA_W+1:0] summary_rec;

    assign in_vld_next = in_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            pos_reg     <= '0;
            ok_reg      <= 1'b1;
            type_hi_reg <= '0;
            src_reg     <= '0;
            dst_reg     <= '0;
            ports_reg   <= '0;
            seq_reg     <= '0;
            ack_reg     <= '0;
            flags_reg   <= '0;
            hw_reg      <= thpc_pkg::MIN_HDR_WORDS;
            cnt_reg     <= '0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            pos_reg     <= pos_next;
            cnt_reg     <= cnt_next;
            // The header fields return to their reset values after the final byte.
            if (in_vld_reg && last_reg)
            begin
                ok_reg      <= 1'b1;
                type_hi_reg <= '0;
                src_reg     <= '0;
                dst_reg     <= '0;
                ports_reg   <= '0;
                seq_reg     <= '0;
                ack_reg     <= '0;
                flags_reg   <= '0;
                hw_reg      <= thpc_pkg::MIN_HDR_WORDS;
            end
            else if (in_vld_reg)
            begin
                ok_reg      <= ok_next;
                type_hi_reg <= type_hi_next;
                src_reg     <= src_next;
                dst_reg     <= dst_next;
                ports_reg   <= ports_next;
                seq_reg     <= seq_next;
                ack_reg     <= ack_next;
                flags_reg   <= flags_next;
                hw_reg      <= hw_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            byte_reg <= in_byte;
            last_reg <= in_last;
        end
    end

    // The offset saturates at all ones; the saturated increment is also the frame length.
    assign pos_inc = (pos_reg != '1) ? pos_reg + LB'(1) : pos_reg;
    assign payload_start = LB'(thpc_pkg::TCP_START_POS) + LB'({hw_reg, 2'b00});

    always_comb
    begin
        ok_next      = ok_reg;
        type_hi_next = type_hi_reg;
        src_next     = src_reg;
        dst_next     = dst_reg;
        ports_next   = ports_reg;
        seq_next     = seq_reg;
        ack_next     = ack_reg;
        flags_next   = flags_reg;
        hw_next      = hw_reg;
        if (pos_reg == LB'(thpc_pkg::ETH_TYPE_HI_POS))
        begin
            type_hi_next = byte_reg;
        end
        else if (pos_reg == LB'(thpc_pkg::ETH_TYPE_LO_POS))
        begin
            if (!(type_hi_reg == thpc_pkg::ETH_TYPE_IPV4_HI &&
                  byte_reg == thpc_pkg::ETH_TYPE_IPV4_LO))
            begin
                ok_next = 1'b0;
            end
        end
        else if (pos_reg == LB'(thpc_pkg::IP_PROTO_POS))
        begin
            if (byte_reg != thpc_pkg::IP_PROTO_TCP)
            begin
                ok_next = 1'b0;
            end
        end
        else if (pos_reg >= LB'(thpc_pkg::SRC_ADDR_POS) &&
                 pos_reg <  LB'(thpc_pkg::SRC_ADDR_POS + thpc_pkg::WORD_BYTES))
        begin
            src_next = {src_reg[23:0], byte_reg};
        end
        else if (pos_reg >= LB'(thpc_pkg::DST_ADDR_POS) &&
                 pos_reg <  LB'(thpc_pkg::DST_ADDR_POS + thpc_pkg::WORD_BYTES))
        begin
            dst_next = {dst_reg[23:0], byte_reg};
        end
        else if (pos_reg >= LB'(thpc_pkg::TCP_START_POS) &&
                 pos_reg <  LB'(thpc_pkg::TCP_START_POS + thpc_pkg::WORD_BYTES))
        begin
            ports_next = {ports_reg[23:0], byte_reg};
        end
        else if (pos_reg >= LB'(thpc_pkg::SEQ_POS) &&
                 pos_reg <  LB'(thpc_pkg::SEQ_POS + thpc_pkg::WORD_BYTES))
        begin
            seq_next = {seq_reg[23:0], byte_reg};
        end
        else if (pos_reg >= LB'(thpc_pkg::ACK_POS) &&
                 pos_reg <  LB'(thpc_pkg::ACK_POS + thpc_pkg::WORD_BYTES))
        begin
            ack_next = {ack_reg[23:0], byte_reg};
        end
        else if (pos_reg == LB'(thpc_pkg::DATA_OFFSET_POS))
        begin
            // A data offset below the minimum header size is repaired to it.
            hw_next = (byte_reg[7:4] < thpc_pkg::MIN_HDR_WORDS) ?
                      thpc_pkg::MIN_HDR_WORDS : byte_reg[7:4];
        end
        else if (pos_reg == LB'(thpc_pkg::TCP_FLAGS_POS))
        begin
            flags_next = byte_reg[thpc_pkg::FLAG_W-1:0];
        end
    end

    assign capture = ok_next && (pos_reg >= LB'(thpc_pkg::MIN_PAYLOAD_POS)) &&
                     (pos_reg >= payload_start) && (cnt_reg < CW'(MAX_CAPTURE));
    assign cnt_after = cnt_reg + CW'(capture);
    assign summary = last_reg && ok_next && (cnt_after != '0);
    assign cnt_wide = {{thpc_pkg::CAPLEN_W{1'b0}}, cnt_after};

    assign payload_data = DATA_W'({byte_reg, {PAYLOAD_LSB{1'b0}}});
    assign summary_data = DATA_W'({8'h00, cnt_wide[thpc_pkg::CAPLEN_W-1:0], pos_inc,
                                   flags_reg, ack_reg, seq_reg, ports_reg[15:0],
                                   ports_reg[31:16], dst_reg, src_reg});
    assign payload_rec = {1'b0, thpc_pkg::REC_KIND_PAYLOAD, payload_data};
    assign summary_rec = {1'b1, thpc_pkg::REC_KIND_SUMMARY, summary_data};

    // State only moves on a registered byte; after the final byte it all returns to reset values.
    always_comb
    begin
        pos_next = pos_reg;
        cnt_next = cnt_reg;
        if (in_vld_reg)
        begin
            pos_next = pos_inc;
            cnt_next = cnt_after;
            if (last_reg)
            begin
                pos_next = '0;
                cnt_next = '0;
            end
        end
    end

    assign pending     = in_vld_reg;
    assign push.first  = in_vld_reg && (capture || summary);
    assign push.second = in_vld_reg && capture && summary;
    assign rec0        = capture ? payload_rec : summary_rec;
    assign rec1        = summary_rec;

endmodule

// ----- hw/rtl/thpc_out_fifo.sv -----
// Output record queue: takes up to two records a cycle, releases one on pop.
module thpc_out_fifo #(
    parameter int W = 202
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  thpc_pkg::push_t                  push,
    input  logic [W-1:0]                     rec0,
    input  logic [W-1:0]                     rec1,
    input  logic                             pop,
    output logic                             out_valid,
    output logic [W-1:0]                     out_entry,
    output logic [thpc_pkg::OUTQ_CNT_W-1:0]  count
);

    localparam int PW = thpc_pkg::OUTQ_PTR_W;
    localparam int CNW = thpc_pkg::OUTQ_CNT_W;

    logic [W-1:0]   entries [thpc_pkg::OUTQ_DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNW-1:0] count_reg, count_next;
    logic           do_pop;

    assign do_pop = pop && (count_reg != '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PW'(push.first) + PW'(push.second);
        rd_ptr_next = rd_ptr_reg + PW'(do_pop);
        count_next  = count_reg + CNW'(push.first) + CNW'(push.second) - CNW'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.first)
        begin
            entries[wr_ptr_reg] <= rec0;
        end
        if (push.second)
        begin
            entries[wr_ptr_reg + PW'(1)] <= rec1;
        end
    end

    assign out_valid = (count_reg != '0);
    assign out_entry = entries[rd_ptr_reg];
    assign count     = count_reg;

endmodule
